// ===== src/mpq_pkg.sv =====
// shared types, constants and codes of the max priority queue
package mpq_pkg;

  localparam int DEPTH     = 1024;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CHILD_W   = ADDR_W + 2;
  localparam int STATUS_W  = 3;
  localparam int REQ_W     = 2;

  localparam int IN_DATA_W  = ((KEY_WIDTH + ADDR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((KEY_WIDTH + CNT_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PEEK     = 2'd0,
    REQ_EXTRACT  = 2'd1,
    REQ_INCREASE = 2'd2,
    REQ_INSERT   = 2'd3
  } req_t;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SMALLER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PEEK_CHK,
    S_EXT_CHK,
    S_INC_CHK,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic                        we;
    logic [ADDR_W-1:0]           waddr;
    logic signed [KEY_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]           raddr0;
    logic [ADDR_W-1:0]           raddr1;
  } ram_req_t;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] value;
    logic [STATUS_W-1:0]         status;
    logic [CNT_W-1:0]            count;
  } result_t;

endpackage

// ===== src/mpq_ram.sv =====
// heap key store: one write port, two registered read ports
module mpq_ram (
  input  logic                                 clk,
  input  mpq_pkg::ram_req_t                    req,
  output logic signed [mpq_pkg::KEY_WIDTH-1:0] rdata0,
  output logic signed [mpq_pkg::KEY_WIDTH-1:0] rdata1
);

  logic signed [mpq_pkg::KEY_WIDTH-1:0] mem [mpq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata0 <= mem[req.raddr0];
    rdata1 <= mem[req.raddr1];
  end

endmodule

// ===== src/mpq_ctrl.sv =====
// request sequencer: read, compare and write back one heap level per step
module mpq_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  mpq_pkg::req_t                        req_type,
  input  logic signed [mpq_pkg::KEY_WIDTH-1:0] req_key,
  input  logic [mpq_pkg::ADDR_W-1:0]           req_index,
  output mpq_pkg::ram_req_t                    ram_req,
  input  logic signed [mpq_pkg::KEY_WIDTH-1:0] rdata0,
  input  logic signed [mpq_pkg::KEY_WIDTH-1:0] rdata1,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output mpq_pkg::result_t                     res
);

  mpq_pkg::ctrl_state_t state_r, state_nxt;
  logic [mpq_pkg::CNT_W-1:0]            count_r, count_nxt;
  logic [mpq_pkg::ADDR_W-1:0]           pos_r, pos_nxt;
  logic signed [mpq_pkg::KEY_WIDTH-1:0] key_r, key_nxt;
  logic signed [mpq_pkg::KEY_WIDTH-1:0] value_r, value_nxt;
  logic [mpq_pkg::STATUS_W-1:0]         status_r, status_nxt;

  logic [mpq_pkg::CHILD_W-1:0]          left_idx, right_idx, count_ext;
  logic [mpq_pkg::ADDR_W-1:0]           parent_idx;
  logic                                 left_ok, right_ok;
  logic                                 pick_left, pick_right;
  logic signed [mpq_pkg::KEY_WIDTH-1:0] best_left;

  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = left_idx + mpq_pkg::CHILD_W'(1);
  assign count_ext  = {1'b0, count_r};
  assign left_ok    = left_idx < count_ext;
  assign right_ok   = right_idx < count_ext;
  assign parent_idx = (pos_r - mpq_pkg::ADDR_W'(1)) >> 1;

  // child selection, ties keep the parent and then the left child
  assign pick_left  = left_ok && (key_r < rdata0);
  assign best_left  = pick_left ? rdata0 : key_r;
  assign pick_right = right_ok && (best_left < rdata1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    status_nxt     = status_r;
    ram_req.we     = 1'b0;
    ram_req.waddr  = pos_r;
    ram_req.wdata  = key_r;
    ram_req.raddr0 = '0;
    ram_req.raddr1 = '0;
    req_ready      = 1'b0;
    res_valid      = 1'b0;

    unique case (state_r)
      mpq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          value_nxt  = '0;
          status_nxt = mpq_pkg::ST_OK;
          key_nxt    = req_key;
          pos_nxt    = req_index;
          unique case (req_type)
            mpq_pkg::REQ_PEEK: begin
              ram_req.raddr0 = '0;
              if (count_r == '0) begin
                status_nxt = mpq_pkg::ST_EMPTY;
                state_nxt  = mpq_pkg::S_RESP;
              end else begin
                state_nxt = mpq_pkg::S_PEEK_CHK;
              end
            end
            mpq_pkg::REQ_EXTRACT: begin
              ram_req.raddr0 = '0;
              ram_req.raddr1 = mpq_pkg::ADDR_W'(count_r - mpq_pkg::CNT_W'(1));
              if (count_r == '0) begin
                status_nxt = mpq_pkg::ST_EMPTY;
                state_nxt  = mpq_pkg::S_RESP;
              end else begin
                state_nxt = mpq_pkg::S_EXT_CHK;
              end
            end
            mpq_pkg::REQ_INCREASE: begin
              ram_req.raddr0 = req_index;
              if ({1'b0, req_index} >= count_r) begin
                status_nxt = mpq_pkg::ST_RANGE;
                state_nxt  = mpq_pkg::S_RESP;
              end else begin
                state_nxt = mpq_pkg::S_INC_CHK;
              end
            end
            mpq_pkg::REQ_INSERT: begin
              if (count_r >= mpq_pkg::CNT_W'(mpq_pkg::DEPTH)) begin
                status_nxt = mpq_pkg::ST_FULL;
                state_nxt  = mpq_pkg::S_RESP;
              end else begin
                pos_nxt   = count_r[mpq_pkg::ADDR_W-1:0];
                count_nxt = count_r + mpq_pkg::CNT_W'(1);
                state_nxt = mpq_pkg::S_UP_RD;
              end
            end
            default: state_nxt = mpq_pkg::S_IDLE;
          endcase
        end
      end
      mpq_pkg::S_PEEK_CHK: begin
        value_nxt = rdata0;
        state_nxt = mpq_pkg::S_RESP;
      end
      mpq_pkg::S_EXT_CHK: begin
        // last entry moves to the root and sifts down
        value_nxt = rdata0;
        key_nxt   = rdata1;
        pos_nxt   = '0;
        count_nxt = count_r - mpq_pkg::CNT_W'(1);
        state_nxt = mpq_pkg::S_DN_RD;
      end
      mpq_pkg::S_INC_CHK: begin
        if (key_r < rdata0) begin
          status_nxt = mpq_pkg::ST_SMALLER;
          state_nxt  = mpq_pkg::S_RESP;
        end else begin
          state_nxt = mpq_pkg::S_UP_RD;
        end
      end
      mpq_pkg::S_UP_RD: begin
        ram_req.raddr0 = parent_idx;
        if (pos_r == '0) begin
          ram_req.we = 1'b1;
          state_nxt  = mpq_pkg::S_RESP;
        end else begin
          state_nxt = mpq_pkg::S_UP_CMP;
        end
      end
      mpq_pkg::S_UP_CMP: begin
        ram_req.we = 1'b1;
        if (rdata0 < key_r) begin
          // parent moves down a level
          ram_req.wdata = rdata0;
          pos_nxt       = parent_idx;
          state_nxt     = mpq_pkg::S_UP_RD;
        end else begin
          state_nxt = mpq_pkg::S_RESP;
        end
      end
      mpq_pkg::S_DN_RD: begin
        ram_req.raddr0 = left_idx[mpq_pkg::ADDR_W-1:0];
        ram_req.raddr1 = right_idx[mpq_pkg::ADDR_W-1:0];
        state_nxt      = mpq_pkg::S_DN_CMP;
      end
      mpq_pkg::S_DN_CMP: begin
        ram_req.we = 1'b1;
        if (pick_right) begin
          ram_req.wdata = rdata1;
          pos_nxt       = right_idx[mpq_pkg::ADDR_W-1:0];
          state_nxt     = mpq_pkg::S_DN_RD;
        end else if (pick_left) begin
          ram_req.wdata = rdata0;
          pos_nxt       = left_idx[mpq_pkg::ADDR_W-1:0];
          state_nxt     = mpq_pkg::S_DN_RD;
        end else begin
          state_nxt = mpq_pkg::S_RESP;
        end
      end
      mpq_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = mpq_pkg::S_IDLE;
        end
      end
      default: state_nxt = mpq_pkg::S_IDLE;
    endcase
  end

  assign res.value  = value_r;
  assign res.status = status_r;
  assign res.count  = count_r;

endmodule

// ===== src/max_priority_queue.sv =====
// max priority queue top level: stream ports, heap store, sequencer, result register
// request to result: refused peek, extract or out-of-range increase go straight to the
//   response state; peek reads the root; a smaller increase key is refused once its entry
//   is read; insert and increase climb a level per read-compare-write step, extract descends
//   likewise; a result waits while out_tready is low; one request at a time on the 1024-entry
//   heap through the single key store; reset: rst_n empties, store kept
module max_priority_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mpq_pkg::IN_DATA_W-1:0]     in_tdata,   // key[31:0], index[41:32], zero pad
  input  logic [mpq_pkg::REQ_W-1:0]         in_tuser,   // req_type[1:0]
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mpq_pkg::OUT_DATA_W-1:0]    out_tdata,  // value[31:0], count[42:32], zero pad
  output logic [mpq_pkg::STATUS_W-1:0]      out_tuser   // status[2:0]
);

  mpq_pkg::ram_req_t                    ram_req;
  logic signed [mpq_pkg::KEY_WIDTH-1:0] rdata0, rdata1;
  logic                                 res_valid, res_ready;
  mpq_pkg::result_t                     res;

  logic                                 out_valid_r;
  mpq_pkg::result_t                     out_res_r;

  // heap keys, one entry per heap position
  mpq_ram u_ram (
    .clk    (clk),
    .req    (ram_req),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // request decode and sift sequencing
  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_type  (mpq_pkg::req_t'(in_tuser)),
    .req_key   (in_tdata[mpq_pkg::KEY_WIDTH-1:0]),
    .req_index (in_tdata[mpq_pkg::KEY_WIDTH +: mpq_pkg::ADDR_W]),
    .ram_req   (ram_req),
    .rdata0    (rdata0),
    .rdata1    (rdata1),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // result register: the sequencer hands off and goes back to idle while
  // the result waits for its transfer
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mpq_pkg::OUT_DATA_W - mpq_pkg::KEY_WIDTH - mpq_pkg::CNT_W){1'b0}},
                       out_res_r.count, out_res_r.value};
  assign out_tuser  = out_res_r.status;

endmodule

// ===== src/mpq_checker.sv =====
// port-level checks on the max priority queue, bound to the top level
module mpq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [mpq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [mpq_pkg::STATUS_W-1:0]   out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // entry count never passes the heap depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[mpq_pkg::KEY_WIDTH +: mpq_pkg::CNT_W]
                   <= mpq_pkg::CNT_W'(mpq_pkg::DEPTH))
    else $error("count above depth");

  // status stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= mpq_pkg::ST_RANGE)
    else $error("undefined status code");

  // any failed request carries a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != mpq_pkg::ST_OK |-> out_tdata[mpq_pkg::KEY_WIDTH-1:0] == '0)
    else $error("nonzero value on failed request");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (.*);

// ===== dv/mpq_result_checker.sv =====
`timescale 1ns / 100ps
// result checker for the max priority queue: heap predictor and field-by-field compare
module mpq_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [mpq_pkg::IN_DATA_W-1:0]  in_tdata,   // key[31:0], index[41:32], zero pad
  input  logic [mpq_pkg::REQ_W-1:0]      in_tuser,   // req_type[1:0]
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [mpq_pkg::OUT_DATA_W-1:0] out_tdata,  // value[31:0], count[42:32], zero pad
  input  logic [mpq_pkg::STATUS_W-1:0]   out_tuser,  // status[2:0]
  output int                             fail_count,
  output int                             pending_count
);

  logic signed [mpq_pkg::KEY_WIDTH-1:0] heap_keys [mpq_pkg::DEPTH];
  int unsigned                          heap_len;
  mpq_pkg::result_t                     due_results [$];
  int                                   fail_tally = 0;
  int                                   result_seq = 0;

  function automatic void swap_keys(int unsigned a, int unsigned b);
    logic signed [mpq_pkg::KEY_WIDTH-1:0] t;
    t            = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // climb while the parent holds a strictly smaller key
  function automatic void float_up(int unsigned pos);
    int unsigned parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (heap_keys[parent] >= heap_keys[pos]) break;
      swap_keys(pos, parent);
      pos = parent;
    end
  endfunction

  // serves one request on the mirrored heap and returns the result it must produce
  function automatic mpq_pkg::result_t next_heap_result(mpq_pkg::req_t req,
                                                        logic signed [mpq_pkg::KEY_WIDTH-1:0] key,
                                                        int unsigned pos);
    mpq_pkg::result_t res;
    int unsigned      slot, largest, lc, rc;
    res.value  = '0;
    res.status = mpq_pkg::ST_OK;
    case (req)
      mpq_pkg::REQ_PEEK: begin
        if (heap_len == 0) res.status = mpq_pkg::ST_EMPTY;
        else res.value = heap_keys[0];
      end
      mpq_pkg::REQ_EXTRACT: begin
        if (heap_len == 0) begin
          res.status = mpq_pkg::ST_EMPTY;
        end else begin
          res.value    = heap_keys[0];
          heap_len     = heap_len - 1;
          heap_keys[0] = heap_keys[heap_len];
          slot         = 0;
          while (1) begin
            largest = slot;
            lc      = 2 * slot + 1;
            rc      = 2 * slot + 2;
            if (lc < heap_len && heap_keys[largest] < heap_keys[lc]) largest = lc;
            if (rc < heap_len && heap_keys[largest] < heap_keys[rc]) largest = rc;
            if (largest == slot) break;
            swap_keys(slot, largest);
            slot = largest;
          end
        end
      end
      mpq_pkg::REQ_INCREASE: begin
        if (pos >= heap_len) begin
          res.status = mpq_pkg::ST_RANGE;
        end else if (key < heap_keys[pos]) begin
          res.status = mpq_pkg::ST_SMALLER;
        end else begin
          heap_keys[pos] = key;
          float_up(pos);
        end
      end
      default: begin
        if (heap_len >= mpq_pkg::DEPTH) begin
          res.status = mpq_pkg::ST_FULL;
        end else begin
          heap_keys[heap_len] = key;
          heap_len            = heap_len + 1;
          float_up(heap_len - 1);
        end
      end
    endcase
    res.count = heap_len[mpq_pkg::CNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    mpq_pkg::result_t got;
    mpq_pkg::result_t want;
    if (!rst_n) begin
      heap_len = 0;
      due_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        due_results.push_back(next_heap_result(mpq_pkg::req_t'(in_tuser),
                                               in_tdata[mpq_pkg::KEY_WIDTH-1:0],
                                               32'(in_tdata[mpq_pkg::KEY_WIDTH +:
                                                            mpq_pkg::ADDR_W])));
      if (out_tvalid && out_tready) begin
        got.value  = out_tdata[mpq_pkg::KEY_WIDTH-1:0];
        got.count  = out_tdata[mpq_pkg::KEY_WIDTH +: mpq_pkg::CNT_W];
        got.status = out_tuser;
        result_seq++;
        if (due_results.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("result %0d arrived with nothing outstanding: %s %0d %s %0d %s %0d",
                     result_seq, "value", got.value, "status", got.status,
                     "count", got.count);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            fail_tally++;
            if (fail_tally <= 10)
              $display({"result %0d mismatch: expected value %0d status %0d count %0d,",
                        " got value %0d status %0d count %0d"},
                       result_seq, want.value, want.status, want.count,
                       got.value, got.status, got.count);
          end
        end
      end
    end
    fail_count    <= fail_tally;
    pending_count <= due_results.size();
  end

endmodule

// ===== dv/tb_max_priority_queue.sv =====
`timescale 1ns / 100ps
// testbench top for the max priority queue: stimulus, stall patterns and verdict
module tb_max_priority_queue;

  localparam logic signed [mpq_pkg::KEY_WIDTH-1:0] KEY_MAX =
    {1'b0, {(mpq_pkg::KEY_WIDTH-1){1'b1}}};
  localparam logic signed [mpq_pkg::KEY_WIDTH-1:0] KEY_MIN =
    {1'b1, {(mpq_pkg::KEY_WIDTH-1){1'b0}}};
  localparam logic signed [mpq_pkg::KEY_WIDTH-1:0] KEY_NEG100 = -100;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [mpq_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [mpq_pkg::REQ_W-1:0]      in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [mpq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [mpq_pkg::STATUS_W-1:0]   out_tuser;

  int fail_count;
  int pending_count;

  // heap size once every issued request has been served, used to aim indexes and to tell when the heap is full
  int unsigned size_mirror = 0;
  // sender idling: stretches of back-to-back transfers alternate with gappy ones
  bit          gapless     = 1'b0;
  int unsigned stretch_left = 0;
  // receiver stall pattern: current level of out_tready holds for this many more cycles
  int unsigned ready_hold  = 0;
  int unsigned ready_pick;

  max_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  mpq_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop: well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("** max_priority_queue: FAILED **");
    $finish;
  end

  // result side back-pressure: mostly short stalls, a few long ones, some long ready runs
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 8) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(50, 150);
      end else if (ready_pick < 55) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 20);
      end else if (ready_pick < 92) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(8, 40);
      end
    end
  end

  // idle cycles before the next request transfer
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (stretch_left == 0) begin
      gapless      = ($urandom_range(0, 3) == 0);
      stretch_left = $urandom_range(10, 60);
    end
    stretch_left--;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // extremes, a narrow band that forces ties, or any 32-bit pattern
  function automatic logic signed [mpq_pkg::KEY_WIDTH-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return '0;
        3:       return -1;
        default: return KEY_NEG100;
      endcase
    end
    if (r < 35) return 32'($urandom_range(0, 15)) - 32'd8;
    return $urandom;
  endfunction

  // any position the index field can hold
  function automatic logic [mpq_pkg::ADDR_W-1:0] any_index();
    return mpq_pkg::ADDR_W'($urandom_range(0, mpq_pkg::DEPTH - 1));
  endfunction

  // mostly a live heap position, sometimes anything the field can hold
  function automatic logic [mpq_pkg::ADDR_W-1:0] pick_index();
    if (size_mirror > 0 && $urandom_range(0, 99) < 85)
      return mpq_pkg::ADDR_W'($urandom_range(0, size_mirror - 1));
    return any_index();
  endfunction

  // one request transfer; valid stays high into the next call when no gap is drawn
  task automatic issue(mpq_pkg::req_t req, logic signed [mpq_pkg::KEY_WIDTH-1:0] key,
                       logic [mpq_pkg::ADDR_W-1:0] pos);
    int unsigned                   gap;
    logic [mpq_pkg::IN_DATA_W-1:0] word;
    gap  = sender_gap();
    word = '0;
    word[mpq_pkg::KEY_WIDTH-1:0]                = key;
    word[mpq_pkg::KEY_WIDTH +: mpq_pkg::ADDR_W] = pos;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    if (req == mpq_pkg::REQ_INSERT && size_mirror < mpq_pkg::DEPTH) size_mirror++;
    if (req == mpq_pkg::REQ_EXTRACT && size_mirror > 0) size_mirror--;
  endtask

  // weighted mix of requests; increase keys lean high so that many of them succeed
  task automatic random_request(int unsigned ins_pct, int unsigned ext_pct, int unsigned inc_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins_pct)
      issue(mpq_pkg::REQ_INSERT, pick_key(), any_index());
    else if (r < ins_pct + ext_pct)
      issue(mpq_pkg::REQ_EXTRACT, pick_key(), any_index());
    else if (r < ins_pct + ext_pct + inc_pct)
      issue(mpq_pkg::REQ_INCREASE,
            $urandom_range(0, 1) ? pick_key() : 32'($urandom_range(0, 32'h7fff_ffff)),
            pick_index());
    else
      issue(mpq_pkg::REQ_PEEK, pick_key(), any_index());
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty heap: every read and every increase is refused
    issue(mpq_pkg::REQ_PEEK, KEY_MAX, '1);
    issue(mpq_pkg::REQ_EXTRACT, KEY_MIN, '0);
    issue(mpq_pkg::REQ_INCREASE, KEY_MAX, '0);
    // key extremes; the maximum climbs to the root
    issue(mpq_pkg::REQ_INSERT, KEY_NEG100, '0);
    issue(mpq_pkg::REQ_INSERT, KEY_MAX, 10'h155);
    issue(mpq_pkg::REQ_INSERT, KEY_MIN, 10'h2aa);
    issue(mpq_pkg::REQ_INSERT, '0, '1);
    issue(mpq_pkg::REQ_INSERT, -1, '0);
    issue(mpq_pkg::REQ_PEEK, 32'h5555_5555, 10'h2aa);
    // index at and beyond the entry count
    issue(mpq_pkg::REQ_INCREASE, KEY_MAX, 10'd5);
    issue(mpq_pkg::REQ_INCREASE, KEY_MAX, '1);
    // smaller key refused, equal key accepted as a no-op, larger key climbs; a second maximum ties the root
    issue(mpq_pkg::REQ_INCREASE, KEY_MIN, 10'd0);
    issue(mpq_pkg::REQ_INCREASE, KEY_MAX, 10'd0);
    issue(mpq_pkg::REQ_INCREASE, KEY_MAX - 1, 10'd4);
    issue(mpq_pkg::REQ_INSERT, KEY_MAX, 10'h155);
    issue(mpq_pkg::REQ_INSERT, 32'h5555_5555, 10'h0ff);
    // drain in order, then one more of each read on the empty heap
    repeat (7) issue(mpq_pkg::REQ_EXTRACT, 32'haaaa_aaaa, 10'h300);
    issue(mpq_pkg::REQ_EXTRACT, '0, '0);
    issue(mpq_pkg::REQ_PEEK, KEY_MIN, '1);
    wait_drained();

    // small heap with frequent emptying
    repeat (80) random_request(35, 30, 20);
    wait_drained();

    // grow to full with deep sifts along the way, then knock on the full heap
    while (size_mirror < mpq_pkg::DEPTH) random_request(96, 2, 1);
    repeat (6) issue(mpq_pkg::REQ_INSERT, pick_key(), any_index());
    wait_drained();

    // near-full mix: increases anywhere in the index range, extracts from deep heaps
    repeat (40) random_request(20, 30, 40);
    wait_drained();

    // room for a stray late result
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("** max_priority_queue: PASSED **");
    end else begin
      $display("** max_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule

// ===== max_priority_queue.f =====
src/mpq_pkg.sv
src/mpq_ram.sv
src/mpq_ctrl.sv
src/max_priority_queue.sv
src/mpq_checker.sv
dv/mpq_result_checker.sv
dv/tb_max_priority_queue.sv
